/* rtl/core/mwpg_pkg.sv */
package mwpg_pkg;

  // Channel widths
  localparam int PHASE_W     = 32;
  localparam int CMD_W       = 3;
  localparam int SAMPLE_W    = 17;
  localparam int OUT_TDATA_W = 24;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF = 16;
  localparam int PEAK_DEF      = 32767;

  // Degree table geometry
  localparam int TABLE_ENTRIES  = 360;
  localparam int HALF_ENTRIES   = 180;
  localparam int QUARTER_ENTRY  = 90;
  localparam int IDX_W          = 9;
  localparam int QTAB_DEPTH     = 91;
  localparam int QADDR_W        = 7;

  // Unit triangle top value, Q15
  localparam int UNIT_ONE = 32768;

  // Ceiling reciprocals: hi / 360 for hi < 2^24 (shift 34), m / 180 for m < 2^24 (shift 32)
  localparam int RCP360_W     = 26;
  localparam int RCP360_SHIFT = 34;
  localparam logic [RCP360_W-1:0] RCP_360 = 26'd47721859;
  localparam int RCP180_W     = 25;
  localparam int RCP180_SHIFT = 32;
  localparam logic [RCP180_W-1:0] RCP_180 = 25'd23860930;

  // Scale and quotient operand widths of the ramp path
  localparam int SCALE_W = 16;
  localparam int MID_W   = 24;

  // Waveform selector codes
  localparam logic [CMD_W-1:0] CMD_SINE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SAW   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RSAW  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRI   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SQR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UTRI  = 3'd5;

  // pi/180 in Q31
  localparam longint unsigned DEG_Q31 = 64'd37480660;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  typedef logic [15:0] qtab_t [QTAB_DEPTH];

  // Quarter sine table, 0..90 degrees, built at elaboration (Taylor series to x^15)
  function automatic qtab_t build_qtab(input int unsigned peak);
    qtab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned sum;
    longint unsigned v;
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      x    = longint'(k) * DEG_Q31;
      x2   = (x * x) >> 31;
      term = x;
      pos  = x;
      neg  = 64'd0;
      term = ((term * x2) >> 31) / 64'd6;
      neg  = neg + term;
      term = ((term * x2) >> 31) / 64'd20;
      pos  = pos + term;
      term = ((term * x2) >> 31) / 64'd42;
      neg  = neg + term;
      term = ((term * x2) >> 31) / 64'd72;
      pos  = pos + term;
      term = ((term * x2) >> 31) / 64'd110;
      neg  = neg + term;
      term = ((term * x2) >> 31) / 64'd156;
      pos  = pos + term;
      term = ((term * x2) >> 31) / 64'd210;
      neg  = neg + term;
      sum  = (pos > neg) ? pos - neg : 64'd0;
      v    = (sum * longint'(peak) + (64'd1 << 30)) >> 31;
      if (v > longint'(peak)) begin
        v = longint'(peak);
      end
      tab[k] = v[15:0];
    end
    return tab;
  endfunction

endpackage

/* rtl/core/multi_waveform_phase_generator.sv */
// Waveform generator: one phase request in, one sample out.
// Input channel: in_tdata carries phase_deg (unsigned, PHASE_FRAC_BITS fraction
//   bits, taken modulo 360 degrees); in_tuser carries the waveform selector:
//   0 sine (interpolated table), 1 rising saw, 2 falling saw, 3 triangle,
//   4 square, 5 unit triangle in Q15; other codes give 0.
// Output channel: out_tdata carries the 17-bit two's complement sample.
// Pipeline: six registered stages (mod-360 multiply, remainder,
//   table/scale multiply, rounding, divide-by-180 multiply, output
//   select); out_tvalid is the valid bit of the last one.
// Throughput: one request per clock unless stalled (see below); every stage has its
//   own valid bit and the ready chain lets empty stages fill while the output is held.
// Stall: with out_tready low the sample holds in the output register; the
//   stages behind it keep filling until all hold data, then in_tready drops.
//   Nothing is lost or repeated.
// Reset: rst_n low for one clock empties the pipeline; the sine table is
//   constant, so the block is ready in the first cycle after reset.
module multi_waveform_phase_generator #(
  parameter int PHASE_FRAC_BITS = mwpg_pkg::FRAC_BITS_DEF,
  parameter int PEAK_AMPLITUDE  = mwpg_pkg::PEAK_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mwpg_pkg::PHASE_W-1:0]         in_tdata,   // [31:0] phase_deg
  input  logic [mwpg_pkg::CMD_W-1:0]           in_tuser,   // [2:0] command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mwpg_pkg::OUT_TDATA_W-1:0]     out_tdata   // [16:0] sample, [23:17] zero
);
  import mwpg_pkg::*;

  localparam logic [SAMPLE_W-1:0] PEAK_V = SAMPLE_W'(PEAK_AMPLITUDE);
  localparam logic [SAMPLE_W-1:0] UNIT_V = SAMPLE_W'(UNIT_ONE);

  stage_en_t                  en;
  logic [5:0]                 vld_r;
  logic [IDX_W-1:0]           idx2;
  logic [PHASE_FRAC_BITS-1:0] frac2;
  logic [CMD_W-1:0]           cmd2;
  logic signed [SAMPLE_W-1:0] sine5;
  logic [SAMPLE_W-1:0]        rnd5;
  logic                       half5;
  logic [CMD_W-1:0]           cmd5;
  logic [SAMPLE_W-1:0]        sample_nxt;
  logic [SAMPLE_W-1:0]        sample_r;

  // Ready chain: a stage advances when empty or when the next one advances
  always_comb begin
    en.s6 = !vld_r[5] || out_tready;
    en.s5 = !vld_r[4] || en.s6;
    en.s4 = !vld_r[3] || en.s5;
    en.s3 = !vld_r[2] || en.s4;
    en.s2 = !vld_r[1] || en.s3;
    en.s1 = !vld_r[0] || en.s2;
  end

  assign in_tready = en.s1;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en.s1) vld_r[0] <= in_tvalid;
      if (en.s2) vld_r[1] <= vld_r[0];
      if (en.s3) vld_r[2] <= vld_r[1];
      if (en.s4) vld_r[3] <= vld_r[2];
      if (en.s5) vld_r[4] <= vld_r[3];
      if (en.s6) vld_r[5] <= vld_r[4];
    end
  end

  mwpg_phase_reduce #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_reduce (
    .clk     (clk),
    .en      (en),
    .phase   (in_tdata),
    .cmd     (in_tuser),
    .idx     (idx2),
    .frac    (frac2),
    .cmd_out (cmd2)
  );

  mwpg_sine_interp #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .PEAK_AMPLITUDE  (PEAK_AMPLITUDE)
  ) u_sine (
    .clk  (clk),
    .en   (en),
    .idx  (idx2),
    .frac (frac2),
    .sine (sine5)
  );

  mwpg_ramp_scale #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .PEAK_AMPLITUDE  (PEAK_AMPLITUDE)
  ) u_ramp (
    .clk     (clk),
    .en      (en),
    .idx     (idx2),
    .frac    (frac2),
    .cmd     (cmd2),
    .rnd     (rnd5),
    .half    (half5),
    .cmd_out (cmd5)
  );

  // Stage 6: waveform select and offset
  always_comb begin
    case (cmd5)
      CMD_SINE: sample_nxt = sine5;
      CMD_SAW:  sample_nxt = rnd5 - PEAK_V;
      CMD_RSAW: sample_nxt = PEAK_V - rnd5;
      CMD_TRI:  sample_nxt = half5 ? PEAK_V - rnd5 : rnd5 - PEAK_V;
      CMD_SQR:  sample_nxt = half5 ? PEAK_V : -PEAK_V;
      CMD_UTRI: sample_nxt = half5 ? UNIT_V - rnd5 : rnd5;
      default:  sample_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = vld_r[5];
  assign out_tdata  = {{(OUT_TDATA_W - SAMPLE_W){1'b0}}, sample_r};

  // With the receiver ready the whole chain advances
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input not ready although output is free");

  // Square wave lands only on the two peaks
  a_square_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && en.s6 && cmd5 == CMD_SQR)
      |=> (sample_r == PEAK_V || sample_r == -PEAK_V))
    else $error("square sample off peak");

  // Unused selectors give zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && en.s6 && (cmd5 > CMD_UTRI)) |=> (sample_r == '0))
    else $error("unused selector gave nonzero sample");

  // A held stage keeps its valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !en.s5) |=> vld_r[4])
    else $error("stalled stage lost its request");

endmodule

/* rtl/core/mwpg_phase_reduce.sv */
module mwpg_phase_reduce #(
  parameter int PHASE_FRAC_BITS = mwpg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  mwpg_pkg::stage_en_t           en,
  input  logic [mwpg_pkg::PHASE_W-1:0]  phase,
  input  logic [mwpg_pkg::CMD_W-1:0]    cmd,
  output logic [mwpg_pkg::IDX_W-1:0]    idx,
  output logic [PHASE_FRAC_BITS-1:0]    frac,
  output logic [mwpg_pkg::CMD_W-1:0]    cmd_out
);
  import mwpg_pkg::*;

  localparam int HI_W   = PHASE_W - PHASE_FRAC_BITS;
  localparam int PROD_W = HI_W + RCP360_W;

  logic [HI_W-1:0]            hi1_r;
  logic [PHASE_FRAC_BITS-1:0] lo1_r;
  logic [CMD_W-1:0]           cmd1_r;
  logic [PROD_W-1:0]          prod1_r;
  logic [HI_W-1:0]            quot;
  logic [IDX_W-1:0]           idx_nxt;
  logic [IDX_W-1:0]           idx2_r;
  logic [PHASE_FRAC_BITS-1:0] lo2_r;
  logic [CMD_W-1:0]           cmd2_r;

  // Stage 1: whole degrees times the reciprocal of 360
  always_ff @(posedge clk) begin
    if (en.s1) begin
      hi1_r   <= phase[PHASE_W-1:PHASE_FRAC_BITS];
      lo1_r   <= phase[PHASE_FRAC_BITS-1:0];
      cmd1_r  <= cmd;
      prod1_r <= PROD_W'(phase[PHASE_W-1:PHASE_FRAC_BITS]) * PROD_W'(RCP_360);
    end
  end

  // Stage 2: whole degrees mod 360 (quotient is exact)
  always_comb begin
    quot    = HI_W'(prod1_r >> RCP360_SHIFT);
    idx_nxt = IDX_W'(hi1_r - HI_W'(quot * HI_W'(TABLE_ENTRIES)));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      idx2_r <= idx_nxt;
      lo2_r  <= lo1_r;
      cmd2_r <= cmd1_r;
    end
  end

  assign idx     = idx2_r;
  assign frac    = lo2_r;
  assign cmd_out = cmd2_r;

endmodule

/* rtl/core/mwpg_sine_interp.sv */
module mwpg_sine_interp #(
  parameter int PHASE_FRAC_BITS = mwpg_pkg::FRAC_BITS_DEF,
  parameter int PEAK_AMPLITUDE  = mwpg_pkg::PEAK_DEF
) (
  input  logic                                clk,
  input  mwpg_pkg::stage_en_t                 en,
  input  logic [mwpg_pkg::IDX_W-1:0]          idx,
  input  logic [PHASE_FRAC_BITS-1:0]          frac,
  output logic signed [mwpg_pkg::SAMPLE_W-1:0] sine
);
  import mwpg_pkg::*;

  localparam qtab_t QTAB   = build_qtab(PEAK_AMPLITUDE);
  localparam int    DIFF_W = SAMPLE_W + 1;
  localparam int    PROD_W = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int    SUM_W  = PROD_W + 1;

  // Full-circle entry from the quarter table by symmetry
  function automatic logic signed [SAMPLE_W-1:0] rom_value(input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0]    q;
    logic [QADDR_W-1:0]  m;
    logic [SAMPLE_W-1:0] mag;
    q   = (k < IDX_W'(HALF_ENTRIES)) ? k : k - IDX_W'(HALF_ENTRIES);
    m   = (q <= IDX_W'(QUARTER_ENTRY)) ? QADDR_W'(q) : QADDR_W'(IDX_W'(HALF_ENTRIES) - q);
    mag = {1'b0, QTAB[m]};
    return (k >= IDX_W'(HALF_ENTRIES)) ? -mag : mag;
  endfunction

  logic [IDX_W-1:0]           nxt_idx;
  logic signed [SAMPLE_W-1:0] lo_val;
  logic signed [SAMPLE_W-1:0] hi_val;
  logic signed [SAMPLE_W-1:0] base3_r;
  logic signed [DIFF_W-1:0]   diff3_r;
  logic [PHASE_FRAC_BITS-1:0] frac3_r;
  logic signed [SAMPLE_W-1:0] base4_r;
  logic signed [PROD_W-1:0]   prod4_r;
  logic signed [SUM_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] sine5_r;

  // Stage 3: neighbor entries, upper one wraps to degree 0
  always_comb begin
    nxt_idx = (idx == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx + 1'b1;
    lo_val  = rom_value(idx);
    hi_val  = rom_value(nxt_idx);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      base3_r <= lo_val;
      diff3_r <= DIFF_W'(hi_val) - DIFF_W'(lo_val);
      frac3_r <= frac;
    end
  end

  // Stage 4: slope times fraction
  always_ff @(posedge clk) begin
    if (en.s4) begin
      base4_r <= base3_r;
      prod4_r <= PROD_W'(diff3_r) * PROD_W'($signed({1'b0, frac3_r}));
    end
  end

  // Stage 5: add base, round half up, drop the fraction
  always_comb begin
    acc = (SUM_W'(base4_r) <<< PHASE_FRAC_BITS) + SUM_W'(prod4_r)
        + (SUM_W'(1) <<< (PHASE_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      sine5_r <= SAMPLE_W'(acc >>> PHASE_FRAC_BITS);
    end
  end

  assign sine = sine5_r;

endmodule

/* rtl/core/mwpg_ramp_scale.sv */
module mwpg_ramp_scale #(
  parameter int PHASE_FRAC_BITS = mwpg_pkg::FRAC_BITS_DEF,
  parameter int PEAK_AMPLITUDE  = mwpg_pkg::PEAK_DEF
) (
  input  logic                              clk,
  input  mwpg_pkg::stage_en_t               en,
  input  logic [mwpg_pkg::IDX_W-1:0]        idx,
  input  logic [PHASE_FRAC_BITS-1:0]        frac,
  input  logic [mwpg_pkg::CMD_W-1:0]        cmd,
  output logic [mwpg_pkg::SAMPLE_W-1:0]     rnd,
  output logic                              half,
  output logic [mwpg_pkg::CMD_W-1:0]        cmd_out
);
  import mwpg_pkg::*;

  localparam int T_W    = IDX_W + PHASE_FRAC_BITS;
  localparam int N_W    = SCALE_W + T_W;
  localparam int Q_W    = MID_W + RCP180_W;
  localparam logic [SCALE_W-1:0] SCALE_SAW  = SCALE_W'(PEAK_AMPLITUDE);
  localparam logic [SCALE_W-1:0] SCALE_TRI  = SCALE_W'(2 * PEAK_AMPLITUDE);
  localparam logic [SCALE_W-1:0] SCALE_UNIT = SCALE_W'(UNIT_ONE);
  localparam logic [N_W-1:0]     RND_BIAS   = N_W'(QUARTER_ENTRY) << PHASE_FRAC_BITS;

  logic                 half_nxt;
  logic [IDX_W-1:0]     tidx;
  logic [SCALE_W-1:0]   scale;
  logic [N_W-1:0]       num3_r;
  logic                 half3_r;
  logic [CMD_W-1:0]     cmd3_r;
  logic [MID_W-1:0]     mid4_r;
  logic                 half4_r;
  logic [CMD_W-1:0]     cmd4_r;
  logic [Q_W-1:0]       qprod;
  logic [SAMPLE_W-1:0]  rnd5_r;
  logic                 half5_r;
  logic [CMD_W-1:0]     cmd5_r;

  // Stage 3: pick the ramp operand and its scale; numerator over 180 * 2^F
  always_comb begin
    half_nxt = (idx >= IDX_W'(HALF_ENTRIES));
    tidx     = idx;
    scale    = SCALE_SAW;
    case (cmd)
      CMD_TRI: begin
        scale = SCALE_TRI;
        if (half_nxt) begin
          tidx = idx - IDX_W'(HALF_ENTRIES);
        end
      end
      CMD_UTRI: begin
        scale = SCALE_UNIT;
        if (half_nxt) begin
          tidx = idx - IDX_W'(HALF_ENTRIES);
        end
      end
      default: begin
        scale = SCALE_SAW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      num3_r  <= N_W'(scale) * N_W'({tidx, frac});
      half3_r <= half_nxt;
      cmd3_r  <= cmd;
    end
  end

  // Stage 4: add half the divisor and strip 2^F
  always_ff @(posedge clk) begin
    if (en.s4) begin
      mid4_r  <= MID_W'((num3_r + RND_BIAS) >> PHASE_FRAC_BITS);
      half4_r <= half3_r;
      cmd4_r  <= cmd3_r;
    end
  end

  // Stage 5: divide by 180 through the exact reciprocal
  assign qprod = Q_W'(mid4_r) * Q_W'(RCP_180);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      rnd5_r  <= SAMPLE_W'(qprod >> RCP180_SHIFT);
      half5_r <= half4_r;
      cmd5_r  <= cmd4_r;
    end
  end

  assign rnd     = rnd5_r;
  assign half    = half5_r;
  assign cmd_out = cmd5_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mwpg_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint PEAK = PEAK_DEF;
  localparam longint unsigned FULL_TURN = 64'd360 << FRAC;
  localparam longint unsigned HALF_TURN = 64'd180 << FRAC;
  localparam longint unsigned TWO_P = 2 * PEAK_DEF;
  localparam logic [PHASE_W-1:0] DEG = 32'h0001_0000;

  // selector codes with no waveform behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  // samples that need no arithmetic
  localparam logic [SAMPLE_W-1:0] S_ZERO  = 17'h00000;
  localparam logic [SAMPLE_W-1:0] S_POS_P = 17'h07FFF;
  localparam logic [SAMPLE_W-1:0] S_NEG_P = 17'h18001;
  localparam logic [SAMPLE_W-1:0] S_UNIT  = 17'h08000;

  localparam int N_DIR = 24;
  localparam int N_RANDOM = 1425;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PHASE_W-1:0] in_tdata = '0;     // [31:0] phase_deg
  logic [CMD_W-1:0] in_tuser = '0;       // [2:0] command
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;     // [16:0] sample, [23:17] zero

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [PHASE_W-1:0]  phase;
    bit                  known;
    logic [SAMPLE_W-1:0] val;
  } req_row_t;

  // directed requests; val is used only where known is set
  req_row_t dir_rows [N_DIR] = '{
    '{CMD_SINE, 32'h0, 1'b1, S_ZERO},
    '{CMD_SINE, 90 * DEG, 1'b0, S_ZERO},
    '{CMD_SINE, 270 * DEG, 1'b0, S_ZERO},
    '{CMD_SINE, 359 * DEG + 32'h8000, 1'b0, S_ZERO},
    '{CMD_SINE, 32'hFFFF_FFFF, 1'b0, S_ZERO},
    '{CMD_SAW, 32'h0, 1'b1, S_NEG_P},
    '{CMD_SAW, 360 * DEG, 1'b1, S_NEG_P},
    '{CMD_SAW, 359 * DEG + 32'hFFFF, 1'b0, S_ZERO},
    '{CMD_RSAW, 32'h0, 1'b1, S_POS_P},
    '{CMD_RSAW, 32'hFFFF_FFFF, 1'b0, S_ZERO},
    '{CMD_TRI, 32'h0, 1'b1, S_NEG_P},
    '{CMD_TRI, 180 * DEG, 1'b1, S_POS_P},
    '{CMD_TRI, 180 * DEG - 1, 1'b0, S_ZERO},
    '{CMD_SQR, 32'h0, 1'b1, S_NEG_P},
    '{CMD_SQR, 180 * DEG - 1, 1'b1, S_NEG_P},
    '{CMD_SQR, 180 * DEG, 1'b1, S_POS_P},
    '{CMD_SQR, 32'hFFFF_FFFF, 1'b0, S_ZERO},
    '{CMD_UTRI, 32'h0, 1'b1, S_ZERO},
    '{CMD_UTRI, 180 * DEG, 1'b1, S_UNIT},
    '{CMD_UTRI, 90 * DEG, 1'b0, S_ZERO},
    '{CMD_UTRI, 32'hFFFF_FFFF, 1'b0, S_ZERO},
    '{CMD_UNUSED_A, 32'hFFFF_FFFF, 1'b1, S_ZERO},
    '{CMD_UNUSED_B, 32'h1234_5678, 1'b1, S_ZERO},
    '{CMD_UNUSED_B, 32'h0, 1'b1, S_ZERO}
  };

  longint sine_tab [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] pending_samples [$];
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int in_stall_cycles = 0;
  int idle_cycles = 0;
  int cmd_count [8];
  bit hold_req = 1'b0;

  multi_waveform_phase_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // sine of a whole degree, Taylor series to x^15 in Q31, scaled by the peak
  function automatic longint sine_of_degree(input int deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned sum;
    longint unsigned v;
    int m;
    m = deg % 180;
    if (m > 90) begin
      m = 180 - m;
    end
    x = longint'(m) * 64'd37480660;
    x2 = (x * x) >> 31;
    term = x;
    pos = x;
    neg = 0;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 31) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    sum = (pos > neg) ? pos - neg : 0;
    v = (sum * longint'(PEAK) + (64'd1 << 30)) >> 31;
    if (v > longint'(PEAK)) begin
      v = PEAK;
    end
    return (deg >= 180) ? -longint'(v) : longint'(v);
  endfunction

  // round to nearest, ties up
  function automatic longint ratio_rounded(input longint unsigned num,
                                           input longint unsigned den);
    return longint'((2 * num + den) / (2 * den));
  endfunction

  // expected sample for one request
  function automatic logic [SAMPLE_W-1:0] waveform_sample(input logic [CMD_W-1:0] cmd,
                                                          input logic [PHASE_W-1:0] phase);
    longint unsigned r;
    longint frac;
    longint s0;
    longint s1;
    longint acc;
    longint v;
    int idx;
    int nxt;
    r = {32'b0, phase} % FULL_TURN;
    v = 0;
    case (cmd)
      CMD_SINE: begin
        idx = int'(r >> FRAC);
        frac = r & ((64'd1 << FRAC) - 1);
        nxt = (idx + 1 >= TABLE_ENTRIES) ? 0 : idx + 1;
        s0 = sine_tab[idx];
        s1 = sine_tab[nxt];
        acc = s0 * (64'sd1 <<< FRAC) + (s1 - s0) * frac
              + (64'sd32768 <<< FRAC) + (64'sd1 <<< (FRAC - 1));
        v = (acc >>> FRAC) - 32768;
      end
      CMD_SAW:  v = ratio_rounded(TWO_P * r, FULL_TURN) - PEAK;
      CMD_RSAW: v = PEAK - ratio_rounded(TWO_P * r, FULL_TURN);
      CMD_TRI: begin
        if (r < HALF_TURN) begin
          v = ratio_rounded(TWO_P * r, HALF_TURN) - PEAK;
        end else begin
          v = PEAK - ratio_rounded(TWO_P * (r - HALF_TURN), HALF_TURN);
        end
      end
      CMD_SQR:  v = (r < HALF_TURN) ? -PEAK : PEAK;
      CMD_UTRI: begin
        if (r < HALF_TURN) begin
          v = ratio_rounded(64'd32768 * r, HALF_TURN);
        end else begin
          v = 32768 - ratio_rounded(64'd32768 * (r - HALF_TURN), HALF_TURN);
        end
      end
      default:  v = 0;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // offer one request and record its sample once it is taken
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PHASE_W-1:0] phase,
                              input logic [SAMPLE_W-1:0] exp_sample);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= phase;
    do @(posedge clk); while (!in_tready);
    pending_samples.push_back(exp_sample);
    cmd_count[cmd]++;
    n_sent++;
  endtask

  // random idle after a request; quiet bursts keep the input saturated
  task automatic sender_gap(inout int burst_left);
    int k;
    int gap;
    k = $urandom_range(0, 99);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (k < 4) begin
      burst_left = $urandom_range(20, 60);
    end else if (k < 26) begin
      gap = $urandom_range(1, 3);
    end else if (k < 32) begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_samples();
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PHASE_W-1:0] random_phase();
    int sel;
    int deg;
    sel = $urandom_range(0, 5);
    deg = $urandom_range(0, 359);
    case (sel)
      0, 1: return $urandom;
      2:    return (deg * DEG) | $urandom_range(0, 65535);
      // around whole degrees, the quadrant edges most of all
      3: begin
        if ($urandom_range(0, 1)) begin
          deg = 90 * $urandom_range(0, 4);
        end
        return $urandom_range(0, 1) ? deg * DEG + $urandom_range(0, 3)
                                    : deg * DEG - $urandom_range(0, 3);
      end
      // many turns past zero
      4:    return $urandom_range(1, 181) * FULL_TURN[31:0]
                   + $urandom_range(0, int'(FULL_TURN) - 1);
      default: return 32'hFFFF_FFFF - $urandom_range(0, int'(FULL_TURN));
    endcase
  endfunction

  // receiver: random stalls, plus one long hold on request
  initial begin
    int k;
    @(posedge clk iff rst_n);
    forever begin
      k = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (k < 55) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (k < 90) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 40)) @(posedge clk);
      end
    end
  end

  // sample check against the oldest pending value, plus the zero padding
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %h", $time, out_tdata);
        n_errors++;
      end else begin
        exp_s = pending_samples.pop_front();
        n_checked++;
        if (out_tdata[SAMPLE_W-1:0] !== exp_s) begin
          $display("%0t: sample mismatch, expected %h got %h",
                   $time, exp_s, out_tdata[SAMPLE_W-1:0]);
          n_errors++;
        end
        if (out_tdata[OUT_TDATA_W-1:SAMPLE_W] !== '0) begin
          $display("%0t: tdata padding mismatch, expected %h got %h",
                   $time, 7'h0, out_tdata[OUT_TDATA_W-1:SAMPLE_W]);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer; also counts input stall cycles
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) begin
      in_stall_cycles++;
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d samples pending",
                 $time, idle_cycles, pending_samples.size());
        $display("multi_waveform_phase_generator test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [PHASE_W-1:0] phase;
    int burst_left;
    burst_left = 0;
    foreach (cmd_count[c]) cmd_count[c] = 0;
    for (int d = 0; d < TABLE_ENTRIES; d++) begin
      sine_tab[d] = sine_of_degree(d);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_DIR; i++) begin
      send_request(dir_rows[i].cmd, dir_rows[i].phase,
                   dir_rows[i].known ? dir_rows[i].val
                                     : waveform_sample(dir_rows[i].cmd, dir_rows[i].phase));
      sender_gap(burst_left);
    end
    in_tvalid <= 1'b0;
    wait_all_samples();

    // random requests
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        // long receiver hold while input keeps coming, so the pipe backs up
        hold_req = 1'b1;
        burst_left = 200;
      end
      if (i == 800) begin
        in_tvalid <= 1'b0;
        wait_all_samples();
      end
      cmd = ($urandom_range(0, 99) < 94) ? CMD_W'($urandom_range(0, 5))
                                         : CMD_W'($urandom_range(6, 7));
      phase = random_phase();
      send_request(cmd, phase, waveform_sample(cmd, phase));
      sender_gap(burst_left);
    end
    in_tvalid <= 1'b0;

    wait_all_samples();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d directed), %0d samples checked, %0d input stall cycles",
             n_sent, N_DIR, n_checked, in_stall_cycles);
    $display("per selector: sine %0d saw %0d rsaw %0d tri %0d sqr %0d utri %0d unused %0d",
             cmd_count[CMD_SINE], cmd_count[CMD_SAW], cmd_count[CMD_RSAW],
             cmd_count[CMD_TRI], cmd_count[CMD_SQR], cmd_count[CMD_UTRI],
             cmd_count[CMD_UNUSED_A] + cmd_count[CMD_UNUSED_B]);
    if (n_errors == 0 && pending_samples.size() == 0) begin
      $display("multi_waveform_phase_generator test passed");
    end else begin
      $display("multi_waveform_phase_generator test failed");
    end
    $finish;
  end

endmodule
